@@ rtl/core/hcb_pkg.sv @@
package hcb_pkg;

   localparam int MAX_SYMBOLS = 64;
   localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
   localparam int IDX_W       = $clog2(NODE_DEPTH + 1);
   localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
   localparam int WEIGHT_W    = 22;
   localparam int CODE_W      = 63;
   localparam int LEN_W       = 6;
   localparam int TOTAL_W     = 28;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NODE_DEPTH - 1);

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                used;
      logic [7:0]          symbol;
      logic [IDX_W-1:0]    root;
      logic [CODE_W-1:0]   code;
      logic [LEN_W-1:0]    len;
   } rec_type;

   typedef struct packed {
      logic                valid;
      logic [IDX_W-1:0]    s1;
      logic [IDX_W-1:0]    s2;
      logic [IDX_W-1:0]    node;
      logic [WEIGHT_W-1:0] sum;
   } pend_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ALIGN,
      ST_MERGE,
      ST_COMMIT,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/core/huffman_code_builder_core.sv @@
// load: each symbol waits for its slot to reach the ring head before it is accepted
// build: one ring rotation per merge (n-1 merges) plus one commit rotation
// emit: one more rotation, one result per leaf as it passes the head, stalls on rsp_tready
// sets: a new set is accepted only after the previous one is emitted; each set also spends an align and load waits
// reset: synchronous active-high, clears control and output valid; ring contents stay undefined
module huffman_code_builder_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // symbol[7:0], weight[23:8]
   input  logic          req_tlast,   // is_last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // out_symbol, code_bits, code_length, total_bits, zero pad
   output logic          rsp_tlast    // last_result
);

   localparam int IW = hcb_pkg::IDX_W;
   localparam int CW = hcb_pkg::CNT_W;
   localparam int ND = hcb_pkg::NODE_DEPTH;

   hcb_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      node_ff, node_in;
   hcb_pkg::pend_type  pend_ff, pend_in;
   logic               b1v_ff, b1v_in, b2v_ff, b2v_in;
   logic [IW-1:0]      b1i_ff, b1i_in, b2i_ff, b2i_in;
   logic [hcb_pkg::WEIGHT_W-1:0] b1w_ff, b1w_in, b2w_ff, b2w_in;
   logic [hcb_pkg::TOTAL_W-1:0]  tot_ff, tot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [111:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   hcb_pkg::rec_type ring_q [ND];
   hcb_pkg::rec_type head_rec;
   logic             ring_en, cand, cand_en, load_en, accept, emit_fire, pass_end, is_last_leaf;
   logic [IW-1:0]    idx, last_node;
   logic [hcb_pkg::TOTAL_W-1:0] tot_sum;

   assign idx       = pos_ff + 1'b1;
   assign last_node = IW'({1'b0, cnt_ff, 1'b0} - 1);
   assign pass_end  = (pos_ff == hcb_pkg::LAST_POS);
   assign is_last_leaf = (idx == IW'(cnt_ff));

   genvar g;
   generate
      for (g = 0; g < ND; g++) begin : g_ring
         if (g == ND - 1) begin : g_tail
            hcb_cell u_cell (.clock(clock), .shift_en(ring_en), .d(head_rec), .q(ring_q[g]));
         end else begin : g_mid
            hcb_cell u_cell (.clock(clock), .shift_en(ring_en), .d(ring_q[g+1]),
                             .q(ring_q[g]));
         end
      end
   endgenerate

   hcb_head u_head (
      .rec_in     (ring_q[0]),
      .pend       (pend_ff),
      .idx        (idx),
      .limit      (node_ff),
      .cand_en    (cand_en),
      .load_en    (load_en),
      .load_symbol(req_tdata[7:0]),
      .load_weight(req_tdata[23:8]),
      .rec_out    (head_rec),
      .cand       (cand)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcb_pkg::ST_LOAD: begin
            if (accept && req_tlast) state_in = hcb_pkg::ST_ALIGN;
         end
         hcb_pkg::ST_ALIGN: begin
            if (pos_ff == '0) begin
               state_in = (cnt_ff == CW'(1)) ? hcb_pkg::ST_EMIT : hcb_pkg::ST_MERGE;
            end
         end
         hcb_pkg::ST_MERGE: begin
            if (pass_end && node_ff == last_node) state_in = hcb_pkg::ST_COMMIT;
         end
         hcb_pkg::ST_COMMIT: begin
            if (pass_end) state_in = hcb_pkg::ST_EMIT;
         end
         hcb_pkg::ST_EMIT: begin
            if (pass_end && ring_en) state_in = hcb_pkg::ST_LOAD;
         end
         default: state_in = hcb_pkg::ST_LOAD;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_tready = 1'b0;
      cand_en    = 1'b0;
      emit_fire  = 1'b0;
      ring_en    = 1'b0;
      case (state_ff)
         hcb_pkg::ST_LOAD: begin
            req_tready = (cnt_ff == CW'(hcb_pkg::MAX_SYMBOLS)) || (pos_ff == IW'(cnt_ff));
            ring_en    = 1'b1;
         end
         hcb_pkg::ST_ALIGN: ring_en = (pos_ff != '0);
         hcb_pkg::ST_MERGE: begin
            cand_en = 1'b1;
            ring_en = 1'b1;
         end
         hcb_pkg::ST_COMMIT: ring_en = 1'b1;
         hcb_pkg::ST_EMIT: begin
            emit_fire = (idx <= IW'(cnt_ff)) && (!rsp_valid_ff || rsp_tready);
            ring_en   = (idx > IW'(cnt_ff)) || emit_fire;
         end
         default: ring_en = 1'b0;
      endcase
   end

   assign accept  = req_tvalid && req_tready;
   assign load_en = accept && (cnt_ff != CW'(hcb_pkg::MAX_SYMBOLS));
   assign tot_sum = tot_ff + hcb_pkg::TOTAL_W'(head_rec.weight[15:0])
                           * hcb_pkg::TOTAL_W'(head_rec.len);

   // datapath next values
   always_comb begin
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      node_in = node_ff;
      pend_in = pend_ff;
      b1v_in = b1v_ff; b1i_in = b1i_ff; b1w_in = b1w_ff;
      b2v_in = b2v_ff; b2i_in = b2i_ff; b2w_in = b2w_ff;
      tot_in  = tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (ring_en) pos_in = pass_end ? '0 : pos_ff + 1'b1;
      if (load_en) cnt_in = cnt_ff + 1'b1;

      if (state_ff == hcb_pkg::ST_ALIGN) begin
         node_in       = IW'(cnt_ff) + 1'b1;
         pend_in.valid = 1'b0;
         b1v_in        = 1'b0;
         b2v_in        = 1'b0;
         tot_in        = '0;
      end

      if (cand) begin
         if (!b1v_ff || head_rec.weight < b1w_ff) begin
            b2v_in = b1v_ff; b2i_in = b1i_ff; b2w_in = b1w_ff;
            b1v_in = 1'b1;   b1i_in = idx;    b1w_in = head_rec.weight;
         end else if (!b2v_ff || head_rec.weight < b2w_ff) begin
            b2v_in = 1'b1;   b2i_in = idx;    b2w_in = head_rec.weight;
         end
      end

      if (state_ff == hcb_pkg::ST_MERGE && pass_end) begin
         pend_in.valid = 1'b1;
         pend_in.s1    = b1i_ff;
         pend_in.s2    = b2i_ff;
         pend_in.node  = node_ff;
         pend_in.sum   = b1w_ff + b2w_ff;
         b1v_in        = 1'b0;
         b2v_in        = 1'b0;
         node_in       = node_ff + 1'b1;
      end
      if (state_ff == hcb_pkg::ST_COMMIT && pass_end) pend_in.valid = 1'b0;

      if (emit_fire) begin
         tot_in       = tot_sum;
         rsp_valid_in = 1'b1;
         rsp_last_in  = is_last_leaf;
         rsp_data_in  = {7'd0,
                         is_last_leaf ? tot_sum : hcb_pkg::TOTAL_W'(0),
                         head_rec.len, head_rec.code, head_rec.symbol};
      end
      if (state_ff == hcb_pkg::ST_EMIT && pass_end && ring_en) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcb_pkg::ST_LOAD;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         node_ff      <= '0;
         pend_ff      <= '0;
         b1v_ff       <= 1'b0;
         b2v_ff       <= 1'b0;
         tot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         node_ff      <= node_in;
         pend_ff      <= pend_in;
         b1v_ff       <= b1v_in;
         b2v_ff       <= b2v_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1i_ff      <= b1i_in;
      b1w_ff      <= b1w_in;
      b2i_ff      <= b2i_in;
      b2w_ff      <= b2w_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/core/hcb_cell.sv @@
module hcb_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  hcb_pkg::rec_type d,
   output hcb_pkg::rec_type q
);

   hcb_pkg::rec_type rec_ff;
   hcb_pkg::rec_type rec_in;

   always_comb begin
      rec_in = shift_en ? d : rec_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign q = rec_ff;

endmodule

@@ rtl/core/hcb_head.sv @@
module hcb_head (
   input  hcb_pkg::rec_type                  rec_in,
   input  hcb_pkg::pend_type                 pend,
   input  logic [hcb_pkg::IDX_W-1:0]         idx,
   input  logic [hcb_pkg::IDX_W-1:0]         limit,
   input  logic                              cand_en,
   input  logic                              load_en,
   input  logic [7:0]                        load_symbol,
   input  logic [15:0]                       load_weight,
   output hcb_pkg::rec_type                  rec_out,
   output logic                              cand
);

   always_comb begin
      rec_out = rec_in;
      if (load_en) begin
         rec_out.weight = hcb_pkg::WEIGHT_W'(load_weight);
         rec_out.used   = 1'b0;
         rec_out.symbol = load_symbol;
         rec_out.root   = idx;
         rec_out.code   = '0;
         rec_out.len    = '0;
      end else if (pend.valid) begin
         if (idx == pend.s1 || idx == pend.s2) begin
            rec_out.used = 1'b1;
         end
         if (idx == pend.node) begin
            rec_out.weight = pend.sum;
            rec_out.used   = 1'b0;
         end
         if (rec_in.root == pend.s1) begin
            rec_out.root = pend.node;
            rec_out.len  = rec_in.len + 1'b1;
         end else if (rec_in.root == pend.s2) begin
            rec_out.root = pend.node;
            rec_out.code = rec_in.code | (hcb_pkg::CODE_W'(1) << rec_in.len);
            rec_out.len  = rec_in.len + 1'b1;
         end
      end
      cand = cand_en && !rec_out.used && (idx < limit);
   end

endmodule

@@ sim/hcb_checker.sv @@
module hcb_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [23:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           code_count,
   output int           codes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]                  symbol;
      logic [hcb_pkg::CODE_W-1:0]  code;
      logic [hcb_pkg::LEN_W-1:0]   len;
      logic [hcb_pkg::TOTAL_W-1:0] total;
      logic                        last;
   } code_word_type;

   code_word_type                  code_q[$];
   logic [hcb_pkg::WEIGHT_W-1:0]   tree_weight[1:hcb_pkg::NODE_DEPTH];
   int                             tree_parent[1:hcb_pkg::NODE_DEPTH];
   int                             tree_left[1:hcb_pkg::NODE_DEPTH];
   logic [7:0]                     leaf_sym[1:hcb_pkg::MAX_SYMBOLS];
   int                             leaf_num;

   assign codes_pending = code_q.size();

   function automatic int lightest(int top, int skip);
      int best;
      best = 0;
      for (int j = 1; j <= top; j++) begin
         if (tree_parent[j] == 0 && j != skip &&
             (best == 0 || tree_weight[j] < tree_weight[best]))
            best = j;
      end
      return best;
   endfunction

   task automatic build_codes();
      int                          n, a, b, c, p;
      logic [hcb_pkg::TOTAL_W-1:0] total;
      code_word_type               cw;
      n = leaf_num;
      total = '0;
      for (int k = 1; k <= hcb_pkg::NODE_DEPTH; k++) tree_parent[k] = 0;
      for (int i = n + 1; i <= 2 * n - 1; i++) begin
         a = lightest(i - 1, 0);
         b = lightest(i - 1, a);
         tree_parent[a] = i;
         tree_parent[b] = i;
         tree_left[i] = a;
         tree_weight[i] = tree_weight[a] + tree_weight[b];
      end
      for (int k = 1; k <= n; k++) begin
         cw = '0;
         c = k;
         p = tree_parent[k];
         while (p > n && cw.len < 63) begin
            cw.code[cw.len] = (tree_left[p] != c);
            cw.len++;
            c = p;
            p = tree_parent[p];
         end
         total += hcb_pkg::TOTAL_W'(tree_weight[k]) * hcb_pkg::TOTAL_W'(cw.len);
         cw.symbol = leaf_sym[k];
         if (k == n) begin
            cw.total = total;
            cw.last  = 1'b1;
         end
         code_q.push_back(cw);
      end
      leaf_num = 0;
   endtask

   always @(posedge clock) begin
      code_word_type want, got;
      if (reset) begin
         leaf_num = 0;
         fail_count <= 0;
         code_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (leaf_num < hcb_pkg::MAX_SYMBOLS) begin
               leaf_num = leaf_num + 1;
               leaf_sym[leaf_num]    = req_tdata[7:0];
               tree_weight[leaf_num] = hcb_pkg::WEIGHT_W'(req_tdata[23:8]);
            end
            if (req_tlast) build_codes();
         end
         if (rsp_tvalid && rsp_tready) begin
            got.symbol = rsp_tdata[7:0];
            got.code   = rsp_tdata[70:8];
            got.len    = rsp_tdata[76:71];
            got.total  = rsp_tdata[104:77];
            got.last   = rsp_tlast;
            code_count <= code_count + 1;
            if (code_q.size() == 0) begin
               $display("%0t: unexpected code beat, actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = code_q.pop_front();
               if (got !== want || rsp_tdata[111:105] !== '0) begin
                  $display("%0t: mismatch expected %p actual %p pad %h", $time, want, got,
                           rsp_tdata[111:105]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 60000;

   typedef enum int {
      WT_RANDOM,
      WT_FULL,
      WT_TINY
   } wt_mode_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tlast;
   logic [23:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [111:0] rsp_tdata;
   int           fail_count, code_count, codes_pending;
   int           stall_cycles, sets_sent, symbols_sent;
   bit           quiet;

   huffman_code_builder_core u_dut (.*);

   hcb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= quiet || ($urandom_range(99) >= 18);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCHDOG) begin
         $display("watchdog expired at %0t", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_symbol(logic [7:0] sym, logic [15:0] wt, logic last);
      if (!quiet && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wt, sym};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      symbols_sent++;
      if (last) sets_sent++;
   endtask

   // set of n symbols with random, full-range or tiny weights
   task automatic send_set(int n, wt_mode_type mode);
      logic [15:0] wt;
      for (int i = 0; i < n; i++) begin
         case (mode)
            WT_FULL: wt = 16'($urandom_range(0, 65535));
            WT_TINY: wt = 16'($urandom_range(0, 3));
            default: wt = 16'($urandom_range(0, 300));
         endcase
         send_symbol(8'($urandom_range(0, 255)), wt, i == n - 1);
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      quiet      = 1'b0;
      sets_sent = 0;
      symbols_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single symbol, then extremes
      send_symbol(8'h00, 16'hffff, 1'b1);
      send_symbol(8'hff, 16'h0000, 1'b0);
      send_symbol(8'h00, 16'hffff, 1'b1);
      // zero weights and ties
      for (int i = 0; i < 5; i++) send_symbol(8'(8'h41 + i), 16'h0000, i == 4);
      for (int i = 0; i < 4; i++) send_symbol(8'(8'ha5 ^ i), 16'd7, i == 3);
      // skewed weights for deep codes
      for (int i = 0; i < 9; i++)
         send_symbol(8'(8'h5a + i), 16'(1 << i), i == 8);
      send_symbol(8'h80, 16'h8000, 1'b0);
      send_symbol(8'h7f, 16'h7fff, 1'b1);

      for (int s = 0; s < 35; s++) begin
         quiet = (s >= 20 && s < 28);
         if (s == 10) send_set(64, WT_FULL);
         else if (s == 30) send_set(67, WT_RANDOM);   // beats past full are dropped
         else send_set($urandom_range(2, 6), wt_mode_type'($urandom_range(0, 2)));
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (codes_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d symbols in %0d sets, checked %0d code beats",
               symbols_sent, sets_sent, code_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/hcb_pkg.sv
rtl/core/hcb_cell.sv
rtl/core/hcb_head.sv
rtl/core/huffman_code_builder_core.sv
sim/hcb_checker.sv
sim/tb.sv
